### hw/rtl/gpio_pkg.sv
// Shared types and constants of the GPIO register block.
// Register word map, request codes and the pipeline structs.
// No dependencies.
`default_nettype none

package gpio_pkg;

  localparam int DATA_W    = 32;
  localparam int HIGH_W    = 26;
  localparam int PAD_W     = DATA_W + HIGH_W;
  localparam int IDX_W     = 6;
  localparam int PIN_IDX_W = 6;
  localparam int MAP_W     = 64;

  localparam logic [1:0] REQ_READ  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  localparam int FSEL_WORD     = 0;
  localparam int FSEL_WORDS    = 7;
  localparam int SET_WORD      = 7;
  localparam int CLR_WORD      = 10;
  localparam int LEV_WORD      = 13;
  localparam int EDS_WORD      = 16;
  localparam int DET_WORD      = 19;
  localparam int DET_STRIDE    = 3;
  localparam int DET_KINDS     = 6;
  localparam int PULL_WORD     = 57;
  localparam int PULL_WORDS    = 4;
  localparam int PINS_PER_FSEL = 10;
  localparam int PINS_PER_PULL = 16;
  localparam int FSEL_BITS     = 3;
  localparam int PULL_BITS     = 2;

  localparam int DET_RISE  = 0;
  localparam int DET_FALL  = 1;
  localparam int DET_HIGH  = 2;
  localparam int DET_LOW   = 3;
  localparam int DET_ARISE = 4;
  localparam int DET_AFALL = 5;

  localparam logic [FSEL_BITS-1:0] FSEL_OUTPUT = 3'd1;

  typedef struct packed {
    logic              valid;
    logic [1:0]        kind;
    logic [IDX_W-1:0]  idx;
    logic [DATA_W-1:0] wdata;
    logic [PAD_W-1:0]  pads;
  } req_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] rdata;
    logic [MAP_W-1:0]  latch;
    logic [MAP_W-1:0]  oe;
    logic [MAP_W-1:0]  evt;
  } view_t;

  function automatic logic [MAP_W-1:0] pair_bits(input logic [IDX_W-1:0] idx,
                                                 input int base,
                                                 input logic [DATA_W-1:0] w);
    logic [MAP_W-1:0] r;
    r = '0;
    if (idx == IDX_W'(base)) begin
      r = {{(MAP_W-DATA_W){1'b0}}, w};
    end else if (idx == IDX_W'(base + 1)) begin
      r = {w, {(MAP_W-DATA_W){1'b0}}};
    end
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pair_get(input logic [MAP_W-1:0] v,
                                                 input logic [IDX_W-1:0] idx,
                                                 input int base);
    logic [DATA_W-1:0] r;
    r = (idx == IDX_W'(base)) ? v[DATA_W-1:0] : v[MAP_W-1:DATA_W];
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/gpio_register_block.sv
// Top level of the GPIO register block.
// Depends on gpio_pkg, gpio_req_stage, gpio_regs and gpio_prio.
//
// Usage:
//   A request is taken at a rising edge with start high and busy low. It is
//   a bus read, a bus write or a pin sample tick (pad levels on in_pins_*).
//   Every request yields one result, marked by out_valid for one cycle.
//   The request is first registered in the input register of gpio_req_stage;
//   out_valid and the result are then registered in gpio_regs. Throughput:
//   one request per cycle while busy is low; busy is high during reset and
//   stays high until a rising edge with rst_n high, and is low from then on.
//   The state update is a single pass of logic between the input register
//   and the state/read-data registers.
//   Result fields show the output latch, output enables (function select 1),
//   per-bank interrupt lines and the lowest pending event pin after that
//   request; out_rdata carries read data for reads and zero otherwise.
//   Reset (rst_n low, synchronous) clears all pin state, drops requests in
//   flight and holds busy high. The receiver cannot stall; results are not
//   held beyond their one cycle.
`default_nettype none

module gpio_register_block #(
  parameter int PIN_COUNT = 58
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [1:0]                       in_req_type,
  input  wire logic [gpio_pkg::IDX_W-1:0]       in_word_index,
  input  wire logic [gpio_pkg::DATA_W-1:0]      in_wdata,
  input  wire logic [gpio_pkg::DATA_W-1:0]      in_pins_low,
  input  wire logic [gpio_pkg::HIGH_W-1:0]      in_pins_high,
  output logic                                  out_valid,
  output logic [gpio_pkg::DATA_W-1:0]           out_rdata,
  output logic [gpio_pkg::DATA_W-1:0]           out_drive_low,
  output logic [gpio_pkg::HIGH_W-1:0]           out_drive_high,
  output logic [gpio_pkg::DATA_W-1:0]           out_enable_low,
  output logic [gpio_pkg::HIGH_W-1:0]           out_enable_high,
  output logic                                  out_irq_bank0,
  output logic                                  out_irq_bank1,
  output logic [gpio_pkg::PIN_IDX_W-1:0]        out_first_event_pin
);
  import gpio_pkg::*;

  req_t  req;
  view_t view;

  gpio_req_stage u_req (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_word_index (in_word_index),
    .in_wdata      (in_wdata),
    .in_pins_low   (in_pins_low),
    .in_pins_high  (in_pins_high),
    .req           (req)
  );

  gpio_regs #(
    .PIN_COUNT (PIN_COUNT)
  ) u_regs (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .view  (view)
  );

  gpio_prio #(
    .PIN_COUNT (PIN_COUNT)
  ) u_prio (
    .evt       (view.evt[PIN_COUNT-1:0]),
    .first_pin (out_first_event_pin)
  );

  assign out_valid       = view.valid;
  assign out_rdata       = view.rdata;
  assign out_drive_low   = view.latch[DATA_W-1:0];
  assign out_drive_high  = view.latch[DATA_W +: HIGH_W];
  assign out_enable_low  = view.oe[DATA_W-1:0];
  assign out_enable_high = view.oe[DATA_W +: HIGH_W];
  assign out_irq_bank0   = |view.evt[DATA_W-1:0];
  assign out_irq_bank1   = |view.evt[MAP_W-1:DATA_W];

endmodule

`default_nettype wire

### hw/rtl/gpio_req_stage.sv
// Input register of GPIO block: captures one request per cycle unless busy.
// Depends on gpio_pkg.
`default_nettype none

module gpio_req_stage (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [1:0]                    in_req_type,
  input  wire logic [gpio_pkg::IDX_W-1:0]    in_word_index,
  input  wire logic [gpio_pkg::DATA_W-1:0]   in_wdata,
  input  wire logic [gpio_pkg::DATA_W-1:0]   in_pins_low,
  input  wire logic [gpio_pkg::HIGH_W-1:0]   in_pins_high,
  output gpio_pkg::req_t                     req
);
  import gpio_pkg::*;

  logic busy_r;
  req_t req_r;
  logic accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      req_r.valid <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      req_r.valid <= accept;
      if (accept) begin
        req_r.kind  <= in_req_type;
        req_r.idx   <= in_word_index;
        req_r.wdata <= in_wdata;
        req_r.pads  <= {in_pins_high, in_pins_low};
      end
    end
  end

  assign req = req_r;

endmodule

`default_nettype wire

### hw/rtl/gpio_regs.sv
// Register file of the GPIO register block: per-pin state, read mux,
// write decode and pin-sample event detection. Depends on gpio_pkg.
`default_nettype none

module gpio_regs #(
  parameter int PIN_COUNT = 58
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  gpio_pkg::req_t  req,
  output gpio_pkg::view_t view
);
  import gpio_pkg::*;

  logic [PIN_COUNT-1:0][FSEL_BITS-1:0] fsel_r, fsel_nxt;
  logic [PIN_COUNT-1:0][PULL_BITS-1:0] pull_r, pull_nxt;
  logic [DET_KINDS-1:0][PIN_COUNT-1:0] det_r, det_nxt;
  logic [PIN_COUNT-1:0] latch_r, latch_nxt;
  logic [PIN_COUNT-1:0] evt_r, evt_nxt;
  logic [PIN_COUNT-1:0] lev_r, lev_nxt;
  logic [PIN_COUNT-1:0] prev_r, prev_nxt;
  logic [PIN_COUNT-1:0] oe;
  logic                 out_valid_r;
  logic [DATA_W-1:0]    rdata_r, rdata_nxt;

  logic [FSEL_WORDS-1:0][DATA_W-1:0] fsel_rd;
  logic [PULL_WORDS-1:0][DATA_W-1:0] pull_rd;

  logic wr, rd, tick;
  logic [MAP_W-1:0]     pads64;
  logic [PIN_COUNT-1:0] now, hit;

  assign wr   = req.valid && (req.kind == REQ_WRITE);
  assign rd   = req.valid && (req.kind == REQ_READ);
  assign tick = req.valid && (req.kind == REQ_TICK);

  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
    localparam int FW = p / PINS_PER_FSEL;
    localparam int FS = p % PINS_PER_FSEL;
    localparam int PW = p / PINS_PER_PULL;
    localparam int PS = p % PINS_PER_PULL;
    assign fsel_nxt[p] = (wr && req.idx == IDX_W'(FSEL_WORD + FW)) ?
                         req.wdata[FSEL_BITS*FS +: FSEL_BITS] : fsel_r[p];
    assign pull_nxt[p] = (wr && req.idx == IDX_W'(PULL_WORD + PW)) ?
                         req.wdata[PULL_BITS*PS +: PULL_BITS] : pull_r[p];
    assign oe[p] = (fsel_r[p] == FSEL_OUTPUT);
  end

  for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_fsel_rd
    for (genvar i = 0; i < PINS_PER_FSEL; i++) begin : g_slot
      if (w * PINS_PER_FSEL + i < PIN_COUNT) begin : g_on
        assign fsel_rd[w][FSEL_BITS*i +: FSEL_BITS] = fsel_r[w * PINS_PER_FSEL + i];
      end else begin : g_off
        assign fsel_rd[w][FSEL_BITS*i +: FSEL_BITS] = '0;
      end
    end
    assign fsel_rd[w][DATA_W-1:FSEL_BITS*PINS_PER_FSEL] = '0;
  end

  for (genvar w = 0; w < PULL_WORDS; w++) begin : g_pull_rd
    for (genvar i = 0; i < PINS_PER_PULL; i++) begin : g_slot
      if (w * PINS_PER_PULL + i < PIN_COUNT) begin : g_on
        assign pull_rd[w][PULL_BITS*i +: PULL_BITS] = pull_r[w * PINS_PER_PULL + i];
      end else begin : g_off
        assign pull_rd[w][PULL_BITS*i +: PULL_BITS] = '0;
      end
    end
  end

  assign pads64 = MAP_W'(req.pads);
  assign now    = pads64[PIN_COUNT-1:0];
  assign hit    = (~lev_r & now & (det_r[DET_RISE] | det_r[DET_ARISE]))
                | (lev_r & ~now & (det_r[DET_FALL] | det_r[DET_AFALL]))
                | (now & det_r[DET_HIGH])
                | (~now & det_r[DET_LOW]);

  always_comb begin
    latch_nxt = latch_r;
    evt_nxt   = evt_r;
    lev_nxt   = lev_r;
    prev_nxt  = prev_r;
    det_nxt   = det_r;
    if (wr) begin
      latch_nxt = (latch_r | PIN_COUNT'(pair_bits(req.idx, SET_WORD, req.wdata)))
                & ~PIN_COUNT'(pair_bits(req.idx, CLR_WORD, req.wdata));
      evt_nxt   = evt_r & ~PIN_COUNT'(pair_bits(req.idx, EDS_WORD, req.wdata));
      for (int k = 0; k < DET_KINDS; k++) begin
        det_nxt[k] = PIN_COUNT'((MAP_W'(det_r[k])
                     & ~pair_bits(req.idx, DET_WORD + DET_STRIDE * k, '1))
                     | pair_bits(req.idx, DET_WORD + DET_STRIDE * k, req.wdata));
      end
    end
    if (tick) begin
      prev_nxt = lev_r;
      lev_nxt  = now;
      evt_nxt  = evt_r | hit;
    end
  end

  always_comb begin
    rdata_nxt = '0;
    if (rd) begin
      if (req.idx < IDX_W'(FSEL_WORD + FSEL_WORDS)) begin
        for (int w = 0; w < FSEL_WORDS; w++) begin
          if (req.idx == IDX_W'(FSEL_WORD + w)) begin
            rdata_nxt = fsel_rd[w];
          end
        end
      end else if (req.idx == IDX_W'(LEV_WORD) || req.idx == IDX_W'(LEV_WORD + 1)) begin
        rdata_nxt = pair_get(MAP_W'(lev_r), req.idx, LEV_WORD);
      end else if (req.idx == IDX_W'(EDS_WORD) || req.idx == IDX_W'(EDS_WORD + 1)) begin
        rdata_nxt = pair_get(MAP_W'(evt_r), req.idx, EDS_WORD);
      end else begin
        for (int k = 0; k < DET_KINDS; k++) begin
          if (req.idx == IDX_W'(DET_WORD + DET_STRIDE * k) ||
              req.idx == IDX_W'(DET_WORD + DET_STRIDE * k + 1)) begin
            rdata_nxt = pair_get(MAP_W'(det_r[k]), req.idx, DET_WORD + DET_STRIDE * k);
          end
        end
        for (int w = 0; w < PULL_WORDS; w++) begin
          if (req.idx == IDX_W'(PULL_WORD + w)) begin
            rdata_nxt = pull_rd[w];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsel_r      <= '0;
      pull_r      <= '0;
      det_r       <= '0;
      latch_r     <= '0;
      evt_r       <= '0;
      lev_r       <= '0;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsel_r      <= fsel_nxt;
      pull_r      <= pull_nxt;
      det_r       <= det_nxt;
      latch_r     <= latch_nxt;
      evt_r       <= evt_nxt;
      lev_r       <= lev_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= rdata_nxt;
  end

  assign view.valid = out_valid_r;
  assign view.rdata = rdata_r;
  assign view.latch = MAP_W'(latch_r);
  assign view.oe    = MAP_W'(oe);
  assign view.evt   = MAP_W'(evt_r);

endmodule

`default_nettype wire

### hw/rtl/gpio_prio.sv
// Lowest-set-bit encoder for the pending event pin.
// Depends on gpio_pkg.
`default_nettype none

module gpio_prio #(
  parameter int PIN_COUNT = 58
) (
  input  wire logic [PIN_COUNT-1:0]        evt,
  output logic [gpio_pkg::PIN_IDX_W-1:0]   first_pin
);
  import gpio_pkg::*;

  logic [PIN_COUNT-1:0] low1;
  logic [PIN_IDX_W-1:0] pos;

  assign low1 = evt & (~evt + PIN_COUNT'(1));

  always_comb begin
    pos = '0;
    for (int p = 0; p < PIN_COUNT; p++) begin
      if (low1[p]) begin
        pos = pos | PIN_IDX_W'(p);
      end
    end
  end

  assign first_pin = (evt == '0) ? PIN_IDX_W'(PIN_COUNT) : pos;

endmodule

`default_nettype wire

### hw/rtl/gpio_checker.sv
// Port-level checks of the GPIO register block and the bind that attaches
// them. Depends on gpio_pkg and gpio_register_block.
`default_nettype none

module gpio_checker #(
  parameter int PIN_COUNT = 58
) (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             start,
  input wire logic                             busy,
  input wire logic                             out_valid,
  input wire logic                             out_irq_bank0,
  input wire logic                             out_irq_bank1,
  input wire logic [gpio_pkg::PIN_IDX_W-1:0]   out_first_event_pin
);
  import gpio_pkg::*;

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> ##1 out_valid)
    else $error("request without result");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 2))
    else $error("result without request");

  a_none_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_irq_bank0 && !out_irq_bank1) |->
      (out_first_event_pin == PIN_IDX_W'(PIN_COUNT)))
    else $error("event pin reported with no interrupt");

  a_bank0_first: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_irq_bank0) |-> (out_first_event_pin < PIN_IDX_W'(DATA_W)))
    else $error("bank 0 interrupt but first event pin in bank 1");

endmodule

bind gpio_register_block gpio_checker #(.PIN_COUNT(PIN_COUNT)) u_gpio_checker (.*);

`default_nettype wire
